/* rtl/core/mtab2_pkg.sv */
// Package for the membrane transport AB2 step block.
// Holds Q16.16 constants, register indexes and a shared saturation helper function.
// No dependencies.
package mtab2_pkg;
	localparam int unsigned QW = 32;
	localparam int unsigned CW = 31;
	localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFFFFFF;
	localparam logic signed [QW-1:0] Q_MIN = 32'sh80000000;
	localparam logic [2:0] REG_LP = 3'd0;
	localparam logic [2:0] REG_RG = 3'd1;
	localparam logic [2:0] REG_TK = 3'd2;
	localparam logic [2:0] REG_AREA = 3'd3;
	localparam logic [2:0] REG_PS_A = 3'd4;
	localparam logic [2:0] REG_PS_B = 3'd5;
	localparam logic [2:0] REG_DT = 3'd6;
	localparam logic [CW-1:0] DT_RESET = 31'd65536;

	typedef struct packed {
		logic start;
		logic first;
	} lane_ctl_t;

	// Saturates a 66 bit signed value to 32 bits, with an overflow flag.
	function automatic logic [QW:0] sat66(input logic signed [65:0] v);
		logic [QW:0] r;
		if (v > 66'sd2147483647) r = {1'b1, Q_MAX};
		else if (v < -66'sd2147483648) r = {1'b1, Q_MIN};
		else r = {1'b0, v[QW-1:0]};
		return r;
	endfunction
endpackage

/* rtl/core/mtab2_lane.sv */
// One transport lane: rate product chain and integration for one quantity.
// Uses mtab2_pkg; a shared multiplier steps through the chain one product a cycle.
module mtab2_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mtab2_pkg::lane_ctl_t         ctl,
	input  logic signed [31:0]           k0,
	input  logic signed [31:0]           k1,
	input  logic signed [31:0]           k2,
	input  logic signed [31:0]           k3,
	input  logic [1:0]                   n_mul,
	input  logic                         negate,
	input  logic signed [31:0]           diff,
	input  logic signed [31:0]           y_old,
	input  logic signed [31:0]           prev_rate,
	input  logic signed [31:0]           dt,
	output logic                         done,
	output logic signed [31:0]           y_new,
	output logic signed [31:0]           rate,
	output logic                         flt
);
	typedef enum logic [2:0] {L_IDLE, L_MUL, L_RATE, L_TERM, L_INT, L_DONE} lst_t;
	localparam logic signed [31:0] Q_MIN_L = mtab2_pkg::Q_MIN;
	lst_t st_q;
	logic [2:0] k_q;
	logic signed [31:0] p_q;
	logic signed [31:0] rate_q;
	logic first_q;
	logic flt_q;
	logic signed [31:0] opb;
	logic signed [63:0] prod;
	logic [32:0] sres;
	logic signed [65:0] t66;
	logic signed [65:0] a66;
	logic [32:0] tsat;
	logic [32:0] ysat;

	always_comb begin
		case (k_q)
			3'd0: opb = k1;
			3'd1: opb = k2;
			3'd2: opb = k3;
			default: opb = diff;
		endcase
	end

	always_comb begin
		prod = (st_q == L_INT) ? (p_q * dt) : (p_q * opb);
		sres = mtab2_pkg::sat66(66'(prod >>> 16));
		t66 = 66'(rate_q) * 66'sd3 - 66'(prev_rate);
		tsat = mtab2_pkg::sat66(t66);
		if (first_q) a66 = 66'(y_old) + 66'(p_q);
		else a66 = 66'(y_old) + 66'(prod >>> 17);
		ysat = mtab2_pkg::sat66(a66);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
			k_q <= '0;
			flt_q <= 1'b0;
			first_q <= 1'b0;
			p_q <= '0;
			rate_q <= '0;
			y_new <= '0;
		end else begin
			unique case (st_q)
				L_IDLE: begin
					if (ctl.start) begin
						p_q <= k0;
						k_q <= (n_mul == 2'd3) ? 3'd0 : ((n_mul == 2'd1) ? 3'd2 : 3'd1);
						first_q <= ctl.first;
						flt_q <= 1'b0;
						st_q <= L_MUL;
					end
				end
				L_MUL: begin
					p_q <= $signed(sres[31:0]);
					flt_q <= flt_q | sres[32];
					if (k_q == 3'd3) st_q <= L_RATE;
					k_q <= k_q + 3'd1;
				end
				L_RATE: begin
					if (negate) begin
						if (p_q == Q_MIN_L) begin
							rate_q <= mtab2_pkg::Q_MAX;
							flt_q <= 1'b1;
						end else rate_q <= -p_q;
					end else rate_q <= p_q;
					st_q <= L_TERM;
				end
				L_TERM: begin
					if (first_q) begin
						p_q <= rate_q;
					end else begin
						p_q <= $signed(tsat[31:0]);
						flt_q <= flt_q | tsat[32];
					end
					st_q <= L_INT;
				end
				L_INT: begin
					if (first_q) begin
						p_q <= $signed(sres[31:0]);
						flt_q <= flt_q | sres[32];
						st_q <= L_DONE;
						k_q <= 3'd7;
					end else begin
						y_new <= $signed(ysat[31:0]);
						flt_q <= flt_q | ysat[32];
						st_q <= L_DONE;
						k_q <= 3'd0;
					end
				end
				L_DONE: begin
					if (k_q == 3'd7) begin
						y_new <= $signed(ysat[31:0]);
						flt_q <= flt_q | ysat[32];
						k_q <= 3'd0;
					end else begin
						st_q <= L_IDLE;
					end
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	assign done = (st_q == L_DONE) && (k_q != 3'd7);
	assign rate = rate_q;
	assign flt = flt_q;
endmodule

/* rtl/core/mtab2_div.sv */
// Iterative restoring divider: (a*65536)/b truncated toward zero, saturated.
// Uses mtab2_pkg; one quotient bit per cycle, 48 quotient bits in all.
module mtab2_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic               busy,
	output logic signed [31:0] q,
	output logic               ovf
);
	logic [5:0] cnt_q;
	logic [47:0] num_q;
	logic [47:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic neg_q;
	logic [32:0] trial;
	logic [65:0] sq;
	logic [32:0] s;

	assign trial = {rem_q[31:0], num_q[47]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy <= 1'b0;
			num_q <= '0;
			den_q <= '0;
			neg_q <= 1'b0;
			rem_q <= '0;
			quo_q <= '0;
		end else if (start) begin
			num_q <= {(a[31] ? 32'(-a) : 32'(a)), 16'd0};
			den_q <= b[31] ? 32'(-b) : 32'(b);
			neg_q <= a[31] ^ b[31];
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= 6'd48;
			busy <= 1'b1;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], num_q[47]};
				quo_q <= {quo_q[46:0], 1'b0};
			end
			num_q <= {num_q[46:0], 1'b0};
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy <= 1'b0;
		end
	end

	always_comb begin
		sq = neg_q ? -{18'd0, quo_q} : {18'd0, quo_q};
		s = mtab2_pkg::sat66($signed(sq));
		q = $signed(s[31:0]);
		ovf = s[32];
	end
endmodule

/* rtl/core/membrane_transport_ab2_step_top.sv */
// For an advance item the lanes run their multiplier chains of up to four products and
// the integration (on the first step after reset or a load the new value is registered
// in an extra state), then two divisions per solute (four with the default two solutes)
// run in turn on one bit-serial divider. When either volume is zero the divisions are
// skipped. A load item is answered from the idle state without running the lanes.
// Top level of the membrane transport AB2 step block.
// Uses mtab2_pkg, mtab2_lane and mtab2_div.
module membrane_transport_ab2_step_top #(
	parameter int SOLUTES = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// outside_osmolality, inside_osmolality, outside_conc_a, outside_conc_b,
	// inside_conc_a, inside_conc_b, load_water_volume, load_amount_a, load_amount_b
	input  logic [287:0] s_tdata,
	input  logic         s_tuser, // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	// new_water_volume, new_amount_a, new_amount_b, uptake_a, uptake_b
	output logic [159:0] m_tdata,
	output logic         m_tuser, // fault
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [30:0]  cfg_data
);
	typedef enum logic [2:0] {S_IDLE, S_LANES, S_DIV, S_DWAIT, S_OUT} st_t;
	localparam int NL = SOLUTES + 1;
	localparam int SW = (SOLUTES > 1) ? $clog2(SOLUTES) : 1;

	st_t st_q;
	logic [30:0] lp_q, rg_q, tk_q, area_q, psa_q, psb_q, dt_q;
	logic signed [31:0] vol_q, prw_q;
	logic signed [31:0] amt_q [SOLUTES];
	logic signed [31:0] prs_q [SOLUTES];
	logic first_q;
	logic signed [31:0] in_q [6];
	logic signed [31:0] nvol_q;
	logic signed [31:0] namt_q [SOLUTES];
	logic signed [31:0] upt_q [SOLUTES];
	logic signed [31:0] d0_q;
	logic flt_q;
	logic [SW-1:0] si_q;
	logic ph_q;
	logic [159:0] out_q;
	logic fout_q;

	logic [NL-1:0] l_done, l_flt, l_dflt;
	logic signed [31:0] l_y [NL];
	logic signed [31:0] l_r [NL];

	// Inputs are registered on acceptance; lanes start in the following cycle.
	mtab2_pkg::lane_ctl_t ctl_d;
	logic go_q;
	assign ctl_d.start = go_q;
	assign ctl_d.first = first_q;

	genvar g;
	generate
		for (g = 0; g < NL; g++) begin : g_lane
			logic signed [31:0] ps, co, ci, dsat;
			logic [32:0] ds;
			always_comb begin
				ps = (g == 1) ? $signed({1'b0, psa_q}) :
					((g == 2) ? $signed({1'b0, psb_q}) : 32'sd0);
				co = (g == 1) ? in_q[2] : ((g == 2) ? in_q[3] : 32'sd0);
				ci = (g == 1) ? in_q[4] : ((g == 2) ? in_q[5] : 32'sd0);
				if (g == 0) ds = mtab2_pkg::sat66(66'(in_q[0]) - 66'(in_q[1]));
				else ds = mtab2_pkg::sat66(66'(co) - 66'(ci));
				dsat = $signed(ds[31:0]);
			end
			assign l_dflt[g] = ds[32];
			mtab2_lane u_lane (
				.clk(clk), .arst_n(arst_n), .ctl(ctl_d),
				.k0((g == 0) ? $signed({1'b0, lp_q}) : ps),
				.k1($signed({1'b0, area_q})),
				.k2($signed({1'b0, rg_q})),
				.k3((g == 0) ? $signed({1'b0, tk_q}) : $signed({1'b0, area_q})),
				.n_mul((g == 0) ? 2'd3 : 2'd1),
				.negate(g == 0),
				.diff(dsat),
				.y_old((g == 0) ? vol_q : amt_q[(g == 0) ? 0 : g - 1]),
				.prev_rate((g == 0) ? prw_q : prs_q[(g == 0) ? 0 : g - 1]),
				.dt($signed({1'b0, dt_q})),
				.done(l_done[g]), .y_new(l_y[g]), .rate(l_r[g]),
				.flt(l_flt[g])
			);
		end
	endgenerate

	logic dv_start;
	logic signed [31:0] dv_a, dv_b, dv_q;
	logic dv_busy, dv_ovf;
	mtab2_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .a(dv_a), .b(dv_b),
		.busy(dv_busy), .q(dv_q), .ovf(dv_ovf)
	);
	assign dv_start = (st_q == S_DIV);
	assign dv_a = ph_q ? namt_q[si_q] : amt_q[si_q];
	assign dv_b = ph_q ? nvol_q : vol_q;

	logic [32:0] us;
	assign us = mtab2_pkg::sat66(66'(d0_q) - 66'(dv_q));

	assign s_tready = (st_q == S_IDLE) && !go_q && !m_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0; rg_q <= '0; tk_q <= '0; area_q <= '0;
			psa_q <= '0; psb_q <= '0; dt_q <= mtab2_pkg::DT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mtab2_pkg::REG_LP: lp_q <= cfg_data;
				mtab2_pkg::REG_RG: rg_q <= cfg_data;
				mtab2_pkg::REG_TK: tk_q <= cfg_data;
				mtab2_pkg::REG_AREA: area_q <= cfg_data;
				mtab2_pkg::REG_PS_A: psa_q <= cfg_data;
				mtab2_pkg::REG_PS_B: psb_q <= cfg_data;
				mtab2_pkg::REG_DT: dt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			vol_q <= '0; prw_q <= '0; first_q <= 1'b1;
			for (int i = 0; i < SOLUTES; i++) begin
				amt_q[i] <= '0; prs_q[i] <= '0;
				namt_q[i] <= '0; upt_q[i] <= '0;
			end
			for (int i = 0; i < 6; i++) in_q[i] <= '0;
			nvol_q <= '0; d0_q <= '0;
			out_q <= '0; fout_q <= 1'b0;
			m_tvalid <= 1'b0;
			go_q <= 1'b0;
			si_q <= '0; ph_q <= 1'b0; flt_q <= 1'b0;
		end else begin
			go_q <= (st_q == S_IDLE) && s_tvalid && s_tready && !s_tuser;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						for (int i = 0; i < 6; i++) in_q[i] <= s_tdata[32*i +: 32];
						if (s_tuser) begin
							vol_q <= s_tdata[223:192];
							prw_q <= '0;
							for (int i = 0; i < SOLUTES; i++) begin
								amt_q[i] <= (i < 2) ? s_tdata[224 + 32*(i % 2) +: 32] : 32'sd0;
								prs_q[i] <= '0;
							end
							first_q <= 1'b1;
							out_q <= {64'd0, (SOLUTES > 1) ? s_tdata[287:256] : 32'd0,
								s_tdata[255:192]};
							fout_q <= 1'b0;
							m_tvalid <= 1'b1;
						end else begin
							st_q <= S_LANES;
						end
					end
				end
				S_LANES: begin
					if (l_done[0]) begin
						nvol_q <= l_y[0];
						for (int i = 0; i < SOLUTES; i++) namt_q[i] <= l_y[i + 1];
						flt_q <= (|l_flt) | (|l_dflt) | (vol_q == 0) | (l_y[0] == 0);
						si_q <= '0; ph_q <= 1'b0;
						if (vol_q == 0 || l_y[0] == 0) begin
							for (int i = 0; i < SOLUTES; i++) upt_q[i] <= '0;
							st_q <= S_OUT;
						end else st_q <= S_DIV;
					end
				end
				S_DIV: st_q <= S_DWAIT;
				S_DWAIT: begin
					if (!dv_busy) begin
						if (!ph_q) begin
							flt_q <= flt_q | dv_ovf;
							d0_q <= dv_q;
							ph_q <= 1'b1;
							st_q <= S_DIV;
						end else begin
							upt_q[si_q] <= $signed(us[31:0]);
							flt_q <= flt_q | dv_ovf | us[32];
							ph_q <= 1'b0;
							if (32'(si_q) == SOLUTES - 1) st_q <= S_OUT;
							else begin
								si_q <= si_q + 1'b1;
								st_q <= S_DIV;
							end
						end
					end
				end
				S_OUT: begin
					vol_q <= nvol_q;
					prw_q <= l_r[0];
					for (int i = 0; i < SOLUTES; i++) begin
						amt_q[i] <= namt_q[i];
						prs_q[i] <= l_r[i + 1];
					end
					first_q <= 1'b0;
					out_q <= {(SOLUTES > 1) ? upt_q[SOLUTES > 1 ? 1 : 0] : 32'sd0, upt_q[0],
						(SOLUTES > 1) ? namt_q[SOLUTES > 1 ? 1 : 0] : 32'sd0, namt_q[0], nvol_q};
					fout_q <= flt_q;
					m_tvalid <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign m_tdata = out_q;
	assign m_tuser = fout_q;
endmodule

/* rtl/core/mtab2_checker.sv */
// Port-level checker for the membrane transport AB2 step top level.
// Bound to membrane_transport_ab2_step_top; no package use.
module mtab2_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [159:0] m_tdata,
	input logic         m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");
	a_noin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("item taken while result pending");
endmodule

bind membrane_transport_ab2_step_top mtab2_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
